// File: hw/rtl/dlle_pkg.sv
// Shared types, constants and microcode encodings for the linked list engine.
// No dependencies; imported by every module of the block.
package dlle_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;
  localparam int UPC_W = 4;

  localparam logic [1:0] CMD_APPEND   = 2'd0;
  localparam logic [1:0] CMD_DELETE   = 2'd1;
  localparam logic [1:0] CMD_LIST_FWD = 2'd2;
  localparam logic [1:0] CMD_LIST_BWD = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // datapath actions
  localparam logic [3:0] ACT_NOP       = 4'd0;
  localparam logic [3:0] ACT_ACCEPT    = 4'd1;
  localparam logic [3:0] ACT_ALLOC     = 4'd2;
  localparam logic [3:0] ACT_LINK      = 4'd3;
  localparam logic [3:0] ACT_WALK_INIT = 4'd4;
  localparam logic [3:0] ACT_READ      = 4'd5;
  localparam logic [3:0] ACT_ADV       = 4'd6;
  localparam logic [3:0] ACT_UNLINK    = 4'd7;
  localparam logic [3:0] ACT_EMIT_ACK  = 4'd8;
  localparam logic [3:0] ACT_EMIT_ITEM = 4'd9;

  // jump conditions
  localparam logic [2:0] C_NEVER    = 3'd0;
  localparam logic [2:0] C_ALWAYS   = 3'd1;
  localparam logic [2:0] C_FULL     = 3'd2;
  localparam logic [2:0] C_WALK_END = 3'd3;
  localparam logic [2:0] C_NOMATCH  = 3'd4;
  localparam logic [2:0] C_EMPTY    = 3'd5;
  localparam logic [2:0] C_NOTLAST  = 3'd6;
  localparam logic [2:0] C_DISPATCH = 3'd7;

  // program addresses
  localparam logic [UPC_W-1:0] PC_IDLE      = 4'd0;
  localparam logic [UPC_W-1:0] PC_AP_CHK    = 4'd1;
  localparam logic [UPC_W-1:0] PC_AP_ALLOC  = 4'd2;
  localparam logic [UPC_W-1:0] PC_AP_LINK   = 4'd3;
  localparam logic [UPC_W-1:0] PC_DL_INIT   = 4'd4;
  localparam logic [UPC_W-1:0] PC_DL_READ   = 4'd5;
  localparam logic [UPC_W-1:0] PC_DL_CMP    = 4'd6;
  localparam logic [UPC_W-1:0] PC_DL_UNLINK = 4'd7;
  localparam logic [UPC_W-1:0] PC_LS_INIT   = 4'd8;
  localparam logic [UPC_W-1:0] PC_LS_READ   = 4'd9;
  localparam logic [UPC_W-1:0] PC_LS_EMIT   = 4'd10;
  localparam logic [UPC_W-1:0] PC_LS_DONE   = 4'd11;
  localparam logic [UPC_W-1:0] PC_ACK_OK    = 4'd12;
  localparam logic [UPC_W-1:0] PC_ACK_FULL  = 4'd13;
  localparam logic [UPC_W-1:0] PC_ACK_NF    = 4'd14;
  localparam logic [UPC_W-1:0] PC_ACK_EMPTY = 4'd15;

  typedef struct packed {
    logic [3:0]       act;
    logic [2:0]       cond;
    logic [UPC_W-1:0] target;
    logic [1:0]       ack_st;
  } ctrl_word_t;

  typedef struct packed {
    logic full;
    logic walk_end;
    logic nomatch;
    logic empty;
    logic notlast;
  } dp_flags_t;

endpackage

// File: hw/rtl/dlle_ucode_rom.sv
// Microcode store: one control word per program step.
// Depends on dlle_pkg.
module dlle_ucode_rom
  import dlle_pkg::*;
(
  input  logic [UPC_W-1:0] upc,
  output ctrl_word_t       cw
);

  always_comb begin
    case (upc)
      PC_IDLE:      cw = '{ACT_ACCEPT,    C_DISPATCH, PC_IDLE,    ST_OK};
      PC_AP_CHK:    cw = '{ACT_NOP,       C_FULL,     PC_ACK_FULL, ST_OK};
      PC_AP_ALLOC:  cw = '{ACT_ALLOC,     C_NEVER,    PC_IDLE,    ST_OK};
      PC_AP_LINK:   cw = '{ACT_LINK,      C_ALWAYS,   PC_ACK_OK,  ST_OK};
      PC_DL_INIT:   cw = '{ACT_WALK_INIT, C_NEVER,    PC_IDLE,    ST_OK};
      PC_DL_READ:   cw = '{ACT_READ,      C_WALK_END, PC_ACK_NF,  ST_OK};
      PC_DL_CMP:    cw = '{ACT_ADV,       C_NOMATCH,  PC_DL_READ, ST_OK};
      PC_DL_UNLINK: cw = '{ACT_UNLINK,    C_ALWAYS,   PC_ACK_OK,  ST_OK};
      PC_LS_INIT:   cw = '{ACT_WALK_INIT, C_EMPTY,    PC_ACK_EMPTY, ST_OK};
      PC_LS_READ:   cw = '{ACT_READ,      C_NEVER,    PC_IDLE,    ST_OK};
      PC_LS_EMIT:   cw = '{ACT_EMIT_ITEM, C_NOTLAST,  PC_LS_READ, ST_OK};
      PC_LS_DONE:   cw = '{ACT_NOP,       C_ALWAYS,   PC_IDLE,    ST_OK};
      PC_ACK_OK:    cw = '{ACT_EMIT_ACK,  C_ALWAYS,   PC_IDLE,    ST_OK};
      PC_ACK_FULL:  cw = '{ACT_EMIT_ACK,  C_ALWAYS,   PC_IDLE,    ST_FULL};
      PC_ACK_NF:    cw = '{ACT_EMIT_ACK,  C_ALWAYS,   PC_IDLE,    ST_NOTFOUND};
      PC_ACK_EMPTY: cw = '{ACT_EMIT_ACK,  C_ALWAYS,   PC_IDLE,    ST_EMPTY};
      default:      cw = '{ACT_NOP,       C_ALWAYS,   PC_IDLE,    ST_OK};
    endcase
  end

endmodule

// File: hw/rtl/dlle_seq.sv
// Step counter with conditional jumps and command dispatch.
// Depends on dlle_pkg.
module dlle_seq
  import dlle_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  ctrl_word_t       cw,
  input  dp_flags_t        flags,
  input  logic             in_valid,
  input  logic [1:0]       in_cmd,
  input  logic             out_free,
  output logic [UPC_W-1:0] upc,
  output logic             exec
);

  logic [UPC_W-1:0] upc_next;
  logic             take;
  logic             stall;
  logic [UPC_W-1:0] disp;

  always_comb begin
    case (in_cmd)
      CMD_APPEND: disp = PC_AP_CHK;
      CMD_DELETE: disp = PC_DL_INIT;
      default:    disp = PC_LS_INIT;
    endcase
  end

  always_comb begin
    case (cw.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_FULL:     take = flags.full;
      C_WALK_END: take = flags.walk_end;
      C_NOMATCH:  take = flags.nomatch;
      C_EMPTY:    take = flags.empty;
      C_NOTLAST:  take = flags.notlast;
      default:    take = 1'b0;
    endcase
  end

  assign stall = ((cw.act == ACT_ACCEPT) && !in_valid) ||
                 (((cw.act == ACT_EMIT_ACK) || (cw.act == ACT_EMIT_ITEM)) && !out_free);
  assign exec  = !stall;

  always_comb begin
    if (stall) begin
      upc_next = upc;
    end else if (cw.cond == C_DISPATCH) begin
      upc_next = disp;
    end else if (take) begin
      upc_next = cw.target;
    end else begin
      upc_next = upc + UPC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= PC_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

// File: hw/rtl/dlle_datapath.sv
// Node pool memories, list pointers, free-slot stack and result register.
// Depends on dlle_pkg; driven by control words from the sequencer.
module dlle_datapath
  import dlle_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  ctrl_word_t              cw,
  input  logic                    exec,
  input  logic [1:0]              in_cmd,
  input  logic signed [VAL_W-1:0] in_value,
  output dp_flags_t               flags,
  output logic                    out_free,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] out_item_value,
  output logic [1:0]              out_status,
  output logic                    out_last
);

  logic signed [VAL_W-1:0] val_mem [DEPTH];
  logic [IDX_W-1:0]        nxt_mem [DEPTH];
  logic [IDX_W-1:0]        prv_mem [DEPTH];
  logic [IDX_W-1:0]        free_mem [DEPTH];

  logic signed [VAL_W-1:0] val_rd;
  logic [IDX_W-1:0]        nxt_rd;
  logic [IDX_W-1:0]        prv_rd;
  logic [IDX_W-1:0]        free_rd;

  logic [1:0]              cmd_r;
  logic signed [VAL_W-1:0] val_r;
  logic [IDX_W-1:0]        cur;
  logic [IDX_W-1:0]        save_cur;
  logic [CNT_W-1:0]        idx;
  logic [IDX_W-1:0]        head;
  logic [IDX_W-1:0]        tail;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        fresh;
  logic [CNT_W-1:0]        free_cnt;
  logic [IDX_W-1:0]        new_slot;
  logic                    pop_r;

  logic [IDX_W-1:0] alloc_slot;
  logic             is_first;
  logic             is_final;
  logic             bwd;
  logic [CNT_W-1:0] idx_inc;
  logic             do_act;
  logic [3:0]       act;

  logic             nxt_we, prv_we;
  logic [IDX_W-1:0] nxt_wa, nxt_wd, prv_wa, prv_wd;

  assign act        = cw.act;
  assign do_act     = exec;
  assign alloc_slot = pop_r ? free_rd : new_slot;
  assign is_first   = (idx == CNT_W'(1));
  assign is_final   = (idx == count);
  assign bwd        = (cmd_r == CMD_LIST_BWD);
  assign idx_inc    = idx + CNT_W'(1);

  assign flags.full     = (count == CNT_W'(DEPTH));
  assign flags.walk_end = (idx == count);
  assign flags.nomatch  = (val_rd != val_r);
  assign flags.empty    = (count == '0);
  assign flags.notlast  = (idx_inc != count);

  assign out_free = !out_valid || out_ready;

  always_comb begin
    nxt_we = 1'b0;
    nxt_wa = tail;
    nxt_wd = alloc_slot;
    prv_we = 1'b0;
    prv_wa = alloc_slot;
    prv_wd = tail;
    if (do_act && (act == ACT_LINK)) begin
      nxt_we = (count != '0);
      prv_we = 1'b1;
    end else if (do_act && (act == ACT_UNLINK)) begin
      nxt_we = !is_first;
      nxt_wa = prv_rd;
      nxt_wd = nxt_rd;
      prv_we = !is_final;
      prv_wa = nxt_rd;
      prv_wd = prv_rd;
    end
  end

  // pool memories
  always_ff @(posedge clk) begin
    if (do_act && (act == ACT_LINK)) begin
      val_mem[alloc_slot] <= val_r;
    end
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    if (prv_we) begin
      prv_mem[prv_wa] <= prv_wd;
    end
    if (do_act && (act == ACT_UNLINK)) begin
      free_mem[free_cnt[IDX_W-1:0]] <= save_cur;
    end
    if (do_act && (act == ACT_READ)) begin
      val_rd <= val_mem[cur];
      nxt_rd <= nxt_mem[cur];
      prv_rd <= prv_mem[cur];
    end
    if (do_act && (act == ACT_ALLOC) && (free_cnt != '0)) begin
      free_rd <= free_mem[IDX_W'(free_cnt - CNT_W'(1))];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (do_act) begin
      case (act)
        ACT_ACCEPT: begin
          cmd_r <= in_cmd;
          val_r <= in_value;
        end
        ACT_ALLOC: begin
          pop_r    <= (free_cnt != '0);
          new_slot <= fresh[IDX_W-1:0];
        end
        ACT_WALK_INIT: begin
          cur <= bwd ? tail : head;
          idx <= '0;
        end
        ACT_ADV: begin
          save_cur <= cur;
          cur      <= nxt_rd;
          idx      <= idx_inc;
        end
        ACT_EMIT_ITEM: begin
          cur <= bwd ? prv_rd : nxt_rd;
          idx <= idx_inc;
        end
        default: begin
        end
      endcase
    end
  end

  // list control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      fresh    <= '0;
      free_cnt <= '0;
    end else if (do_act) begin
      case (act)
        ACT_ALLOC: begin
          if (free_cnt != '0) begin
            free_cnt <= free_cnt - CNT_W'(1);
          end else begin
            fresh <= fresh + CNT_W'(1);
          end
        end
        ACT_LINK: begin
          if (count == '0) begin
            head <= alloc_slot;
          end
          tail  <= alloc_slot;
          count <= count + CNT_W'(1);
        end
        ACT_UNLINK: begin
          if (is_first) begin
            head <= nxt_rd;
          end
          if (is_final) begin
            tail <= prv_rd;
          end
          if (count == CNT_W'(1)) begin
            head <= '0;
            tail <= '0;
          end
          count    <= count - CNT_W'(1);
          free_cnt <= free_cnt + CNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_act && ((act == ACT_EMIT_ACK) || (act == ACT_EMIT_ITEM))) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_act && (act == ACT_EMIT_ACK)) begin
      out_item_value <= '0;
      out_status     <= cw.ack_st;
      out_last       <= 1'b1;
    end else if (do_act && (act == ACT_EMIT_ITEM)) begin
      out_item_value <= val_rd;
      out_status     <= ST_OK;
      out_last       <= !flags.notlast;
    end
  end

endmodule

// File: hw/rtl/doubly_linked_list_engine.sv
// Bounded doubly linked list engine: 64-slot node pool run by a microcoded sequencer.
// Takes a command (append, delete first match, list forward, list backward) and a
// value on the slave stream; answers on the master stream.
// Usage:
//   Slave side: s_axis_tuser carries the command, s_axis_tdata the 32-bit value.
//   One request is taken at a time; s_axis_tready is high only while the engine
//   waits for a new command.
//   Master side: m_axis_tdata is the stored value (zero in acknowledges),
//   m_axis_tuser the status (ok, full, not found, empty), m_axis_tlast marks the
//   final result of a request.
//   Append: one acknowledge, after the full check, slot allocation and link steps.
//   Delete: one acknowledge after a walk of a read and a compare step per node
//   visited, one link per read of the pool memories' single read port.
//   Traversal: one result per stored node, each from a read step, then an emit step.
//   The result register holds a result while m_axis_tready is low; the
//   sequencer waits at its next emit step, no result is dropped.
//   Reset clears the list pointers, node count and free-slot stack at once;
//   the engine is ready in the first cycle after rst falls.
module doubly_linked_list_engine
  import dlle_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] value
  input  logic [1:0]  s_axis_tuser,  // [1:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [31:0] item_value
  output logic [1:0]  m_axis_tuser,  // [1:0] status
  output logic        m_axis_tlast
);

  logic [UPC_W-1:0] upc;
  ctrl_word_t       cw;
  dp_flags_t        flags;
  logic             exec;
  logic             out_free;

  assign s_axis_tready = (cw.act == ACT_ACCEPT) && !rst;

  dlle_ucode_rom u_rom (
    .upc (upc),
    .cw  (cw)
  );

  dlle_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .cw       (cw),
    .flags    (flags),
    .in_valid (s_axis_tvalid),
    .in_cmd   (s_axis_tuser),
    .out_free (out_free),
    .upc      (upc),
    .exec     (exec)
  );

  dlle_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cw             (cw),
    .exec           (exec),
    .in_cmd         (s_axis_tuser),
    .in_value       (s_axis_tdata),
    .flags          (flags),
    .out_free       (out_free),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_item_value (m_axis_tdata),
    .out_status     (m_axis_tuser),
    .out_last       (m_axis_tlast)
  );

endmodule
